@@ hdl/evcpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evcpc_pkg
// Shared types and constants for the control pilot controller.
// ----------------------------------------------------------------------------
package evcpc_pkg;

  localparam logic [2:0] PILOT_A = 3'd0;
  localparam logic [2:0] PILOT_B = 3'd1;
  localparam logic [2:0] PILOT_C = 3'd2;
  localparam logic [2:0] PILOT_D = 3'd3;
  localparam logic [2:0] PILOT_E = 3'd4;
  localparam logic [2:0] PILOT_F = 3'd5;

  localparam logic [1:0] OP_PILOT = 2'd0;
  localparam logic [1:0] OP_LIMIT = 2'd1;
  localparam logic [1:0] OP_AVAIL = 2'd2;

  localparam logic [2:0] REG_MIN_CURRENT    = 3'd0;
  localparam logic [2:0] REG_MAX_CURRENT    = 3'd1;
  localparam logic [2:0] REG_LINEAR_LIMIT   = 3'd2;
  localparam logic [2:0] REG_NO_CURRENT_DTY = 3'd3;
  localparam logic [2:0] REG_DUTY_FLOOR     = 3'd4;
  localparam logic [2:0] REG_DUTY_CEILING   = 3'd5;

  localparam logic [9:0] DISABLED_DUTY = 10'd1000;

  typedef struct packed {
    logic [7:0] min_current;
    logic [7:0] max_current;
    logic [7:0] linear_limit;
    logic [9:0] no_current_duty;
    logic [9:0] duty_floor;
    logic [9:0] duty_ceiling;
  } duty_cfg_t;

  typedef struct packed {
    logic gun;
    logic charging;
    logic ventilation;
    logic fault;
  } pilot_flags_t;

endpackage

@@ hdl/evcpc_duty.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evcpc_duty
// Current limit to pwm duty (tenths of a percent) conversion with clamping.
// ----------------------------------------------------------------------------
module evcpc_duty
  import evcpc_pkg::*;
(
  input  logic [7:0] amps,
  input  duty_cfg_t  cfg,
  output logic [9:0] duty
);

  logic [7:0]  clamped;
  logic [8:0]  two_a;
  logic [19:0] third_prod;
  logic [12:0] lin_duty;
  logic [12:0] hi_duty;
  logic [12:0] raw_duty;

  always_comb begin
    if (amps < cfg.min_current) begin
      clamped = cfg.min_current;
    end else if (amps > cfg.max_current) begin
      clamped = cfg.max_current;
    end else begin
      clamped = amps;
    end
  end

  // a*50/3 = 16a + floor(2a/3); 2a/3 via reciprocal 683/2048
  assign two_a      = {clamped, 1'b0};
  assign third_prod = 20'(two_a) * 20'd683;
  assign lin_duty   = {1'b0, clamped, 4'b0000} + 13'(third_prod[19:11]);
  assign hi_duty    = {3'b000, clamped, 2'b00} + 13'd640;
  assign raw_duty   = (clamped <= cfg.linear_limit) ? lin_duty : hi_duty;

  always_comb begin
    if (amps == 8'd0) begin
      duty = cfg.no_current_duty;
    end else if (raw_duty < {3'b000, cfg.duty_floor}) begin
      duty = cfg.duty_floor;
    end else if (raw_duty > {3'b000, cfg.duty_ceiling}) begin
      duty = cfg.duty_ceiling;
    end else begin
      duty = raw_duty[9:0];
    end
  end

endmodule

@@ hdl/evcpc_pilot_xfer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evcpc_pilot_xfer
// Flag update for a change of pilot state, by previous and new state.
// ----------------------------------------------------------------------------
module evcpc_pilot_xfer
  import evcpc_pkg::*;
(
  input  logic [2:0]   prev_pilot,
  input  logic [2:0]   cur_pilot,
  input  pilot_flags_t flags_in,
  output pilot_flags_t flags_out
);

  logic to_fault;

  assign to_fault = (cur_pilot == PILOT_E) || (cur_pilot == PILOT_F);

  always_comb begin
    flags_out = flags_in;
    case (prev_pilot)
      PILOT_A: begin
        if (cur_pilot == PILOT_B) begin
          flags_out.gun = 1'b1;
        end else if (cur_pilot == PILOT_C || cur_pilot == PILOT_D) begin
          flags_out.gun      = 1'b1;
          flags_out.charging = 1'b1;
          if (cur_pilot == PILOT_D) begin
            flags_out.ventilation = 1'b1;
          end
        end else if (to_fault) begin
          flags_out.fault = 1'b1;
        end
      end
      PILOT_B: begin
        if (cur_pilot == PILOT_A) begin
          flags_out.gun = 1'b0;
        end else if (cur_pilot == PILOT_C || cur_pilot == PILOT_D) begin
          flags_out.charging = 1'b1;
          if (cur_pilot == PILOT_D) begin
            flags_out.ventilation = 1'b1;
          end
        end else if (to_fault) begin
          flags_out.fault = 1'b1;
        end
      end
      PILOT_C, PILOT_D: begin
        if (cur_pilot == PILOT_A) begin
          flags_out.gun      = 1'b0;
          flags_out.charging = 1'b0;
        end else if (cur_pilot == PILOT_B) begin
          flags_out.charging = 1'b0;
        end else if (to_fault) begin
          flags_out.charging = 1'b0;
          flags_out.fault    = 1'b1;
        end
      end
      default: begin
        if (cur_pilot == PILOT_A) begin
          flags_out.gun = 1'b0;
        end else if (cur_pilot == PILOT_B || cur_pilot == PILOT_C) begin
          flags_out.gun = 1'b1;
        end
      end
    endcase
  end

endmodule

@@ hdl/ev_control_pilot_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ev_control_pilot_controller
// Supply-side control pilot controller: pilot state flags and pwm duty.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tuser op, tdata pilot/current/avail
//   out_     out  out_tvalid/out_tready  tuser duty_write, tdata state+duty
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one request per clock sustained while out_tready is high; input to result
// passes the input register, then the result register
// cfg_ready is always high; config, state and valid registers take their reset values under rst_n
// a stalled result holds in the result register while the input register
// still takes a request; stall reaches in_tready only when both are full
// ----------------------------------------------------------------------------
module ev_control_pilot_controller
  import evcpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [15:0] in_tdata,   // pilot_code, current_amps, available
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // duty_write
  output logic [23:0] out_tdata,  // pilot_now, gun_connected, charging_active,
                                  // ventilation_needed, fault_seen,
                                  // pwm_enabled, duty_tenths
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  duty_cfg_t    cfg_r;
  logic         in_vld_r;
  logic [1:0]   op_r;
  logic [2:0]   code_r;
  logic [7:0]   amps_r;
  logic         avail_r;

  logic [2:0]   prev_pilot_r, prev_pilot_nxt;
  logic [2:0]   rep_pilot_r, rep_pilot_nxt;
  pilot_flags_t flags_r, flags_nxt, xfer_flags;
  logic         pwm_r, pwm_nxt;
  logic [7:0]   limit_r, limit_nxt;

  logic         out_vld_r;
  logic         out_wr_r, wr_nxt;
  logic [23:0]  out_data_r;

  logic         adv;
  logic         pilot_upd;
  logic [7:0]   duty_amps;
  logic [9:0]   calc_duty;
  logic [9:0]   duty_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_current     <= 8'd6;
      cfg_r.max_current     <= 8'd80;
      cfg_r.linear_limit    <= 8'd51;
      cfg_r.no_current_duty <= 10'd1000;
      cfg_r.duty_floor      <= 10'd100;
      cfg_r.duty_ceiling    <= 10'd960;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_CURRENT:    cfg_r.min_current     <= cfg_data[7:0];
        REG_MAX_CURRENT:    cfg_r.max_current     <= cfg_data[7:0];
        REG_LINEAR_LIMIT:   cfg_r.linear_limit    <= cfg_data[7:0];
        REG_NO_CURRENT_DTY: cfg_r.no_current_duty <= cfg_data;
        REG_DUTY_FLOOR:     cfg_r.duty_floor      <= cfg_data;
        REG_DUTY_CEILING:   cfg_r.duty_ceiling    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      code_r  <= in_tdata[2:0];
      amps_r  <= in_tdata[10:3];
      avail_r <= in_tdata[11];
    end
  end

  evcpc_pilot_xfer u_xfer (
    .prev_pilot (prev_pilot_r),
    .cur_pilot  (code_r),
    .flags_in   (flags_r),
    .flags_out  (xfer_flags)
  );

  assign duty_amps = (op_r == OP_LIMIT) ? amps_r : limit_r;

  evcpc_duty u_duty (
    .amps (duty_amps),
    .cfg  (cfg_r),
    .duty (calc_duty)
  );

  assign pilot_upd = (op_r == OP_PILOT) && (code_r <= PILOT_F) && (code_r != prev_pilot_r);

  always_comb begin
    prev_pilot_nxt = prev_pilot_r;
    rep_pilot_nxt  = rep_pilot_r;
    flags_nxt      = flags_r;
    pwm_nxt        = pwm_r;
    limit_nxt      = limit_r;
    wr_nxt         = 1'b0;
    duty_nxt       = 10'd0;
    case (op_r)
      OP_PILOT: begin
        if (pilot_upd) begin
          prev_pilot_nxt = code_r;
          rep_pilot_nxt  = code_r;
          flags_nxt      = xfer_flags;
        end
      end
      OP_LIMIT: begin
        limit_nxt = amps_r;
        if (pwm_r) begin
          wr_nxt   = 1'b1;
          duty_nxt = calc_duty;
        end
      end
      OP_AVAIL: begin
        wr_nxt   = 1'b1;
        pwm_nxt  = avail_r;
        duty_nxt = avail_r ? calc_duty : DISABLED_DUTY;
      end
      default: ;
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pilot_r <= PILOT_F;
      rep_pilot_r  <= PILOT_A;
      flags_r      <= '0;
      pwm_r        <= 1'b0;
      limit_r      <= 8'd0;
      out_vld_r    <= 1'b0;
    end else begin
      if (adv) begin
        prev_pilot_r <= prev_pilot_nxt;
        rep_pilot_r  <= rep_pilot_nxt;
        flags_r      <= flags_nxt;
        pwm_r        <= pwm_nxt;
        limit_r      <= limit_nxt;
        out_vld_r    <= 1'b1;
      end else if (out_tready) begin
        out_vld_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_wr_r   <= wr_nxt;
      out_data_r <= {6'b000000, duty_nxt, pwm_nxt, flags_nxt.fault,
                     flags_nxt.ventilation, flags_nxt.charging, flags_nxt.gun,
                     rep_pilot_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_wr_r;
  assign out_tdata  = out_data_r;

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.fault |=> flags_r.fault)
    else $error("fault flag cleared without reset");

  a_vent_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.ventilation |=> flags_r.ventilation)
    else $error("ventilation flag cleared without reset");

  a_no_duty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_wr_r) |-> (out_data_r[17:8] == 10'd0))
    else $error("duty present without duty write");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(op_r) && $stable(amps_r)))
    else $error("input register lost a stalled request");

endmodule
